// File: design/delayed_priority_warning_queue_macros.svh
// Assertion macros for the delayed priority warning queue.
// Used by the port checker; no other dependencies.
`ifndef DELAYED_PRIORITY_WARNING_QUEUE_MACROS_SVH
`define DELAYED_PRIORITY_WARNING_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPWQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dpwq_pkg.sv
// Package for the delayed priority warning queue.
// Field widths, request codes, sequencer states and the list entry type.
package dpwq_pkg;

  localparam int NumIdsDefault = 32;
  localparam int ReqW          = 3;
  localparam int IdW           = 5;
  localparam int PrioW         = 16;
  localparam int DelayW        = 16;

  typedef enum logic [ReqW-1:0] {
    ReqInsert   = 3'd0,
    ReqRemove   = 3'd1,
    ReqDecrease = 3'd2,
    ReqPop      = 3'd3,
    ReqClear    = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    StIdle,
    StDispatch,
    StScanRd,
    StScanChk,
    StShRd,
    StShWr,
    StInsWr,
    StDecRd,
    StDecWr,
    StHeadRd,
    StHeadCap
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [DelayW-1:0] delay;
  } entry_t;

endpackage

// File: design/dpwq_req_if.sv
// Request channel interface: valid/ready plus the request fields.
// Depends on dpwq_pkg.
interface dpwq_req_if;
  logic                        valid;
  logic                        ready;
  logic [dpwq_pkg::ReqW-1:0]   req_type;
  logic [dpwq_pkg::IdW-1:0]    warning_id;
  logic [dpwq_pkg::PrioW-1:0]  priority_req;
  logic [dpwq_pkg::DelayW-1:0] trigger_delay;
  logic [dpwq_pkg::DelayW-1:0] decrement;

  modport source (output valid, req_type, warning_id, priority_req, trigger_delay,
                  decrement, input ready);
  modport sink (input valid, req_type, warning_id, priority_req, trigger_delay,
                decrement, output ready);
endinterface

// File: design/dpwq_res_if.sv
// Result channel interface: valid/ready plus the result fields.
// Depends on dpwq_pkg; CntW sizes head id and count.
interface dpwq_res_if #(
  parameter int CntW = 6
);
  logic                       valid;
  logic                       ready;
  logic                       done_res;
  logic [dpwq_pkg::IdW-1:0]   popped_id;
  logic [dpwq_pkg::PrioW-1:0] popped_priority;
  logic [CntW-1:0]            head_id;
  logic [CntW-1:0]            entry_count;

  modport source (output valid, done_res, popped_id, popped_priority, head_id,
                  entry_count, input ready);
  modport sink (input valid, done_res, popped_id, popped_priority, head_id,
                entry_count, output ready);
endinterface

// File: design/delayed_priority_warning_queue.sv
// Delayed priority warning queue: sorted list in one synchronous RAM, walked by a sequencer.
// A request is dispatched, then scans, shifts or decrements entries as its type needs (an insert
// also writes the new entry, and an insert into an empty list goes straight to that write), then
// reads the head entry and loads the result once the output register is free. One transaction at a
// time; the next request is accepted the cycle after the result loads. Reset: asynchronous, empties list.
// Depends on dpwq_pkg, dpwq_req_if, dpwq_res_if.
module delayed_priority_warning_queue #(
  parameter int NUM_IDS = dpwq_pkg::NumIdsDefault,
  parameter int CntW    = $clog2(NUM_IDS + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpwq_req_if.sink   req_i,
  dpwq_res_if.source res_o
);

  localparam int PosW = $clog2(NUM_IDS);

  dpwq_pkg::entry_t mem [NUM_IDS];
  dpwq_pkg::entry_t rd_data_q;
  logic [PosW-1:0]  rd_addr;
  logic             wr_en;
  logic [PosW-1:0]  wr_addr;
  dpwq_pkg::entry_t wr_data;

  dpwq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic             found_q, found_d;
  logic             done_q, done_d;
  logic [dpwq_pkg::IdW-1:0]   pid_q, pid_d;
  logic [dpwq_pkg::PrioW-1:0] pprio_q, pprio_d;

  logic [dpwq_pkg::ReqW-1:0]   req_type_q;
  logic [dpwq_pkg::IdW-1:0]    wid_q;
  logic [dpwq_pkg::PrioW-1:0]  prio_q;
  logic [dpwq_pkg::DelayW-1:0] delay_q;
  logic [dpwq_pkg::DelayW-1:0] dec_q;

  logic                       out_valid_q, out_valid_d;
  logic                       out_load;
  logic                       out_done_q;
  logic [dpwq_pkg::IdW-1:0]   out_pid_q;
  logic [dpwq_pkg::PrioW-1:0] out_pprio_q;
  logic [CntW-1:0]            out_head_q, out_head_d;
  logic [CntW-1:0]            out_cnt_q;

  logic            accept;
  logic [CntW-1:0] idx_p1, idx_m1;
  logic            last;
  logic            is_insert;
  dpwq_pkg::req_e  req;

  assign accept    = req_i.valid && req_i.ready;
  assign idx_p1    = idx_q + CntW'(1);
  assign idx_m1    = idx_q - CntW'(1);
  assign last      = (idx_p1 == occ_q);
  assign req       = dpwq_pkg::req_e'(req_type_q);
  assign is_insert = (req == dpwq_pkg::ReqInsert);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      wid_q      <= req_i.warning_id;
      prio_q     <= req_i.priority_req;
      delay_q    <= req_i.trigger_delay;
      dec_q      <= req_i.decrement;
    end
    if (out_load) begin
      out_done_q  <= done_q;
      out_pid_q   <= pid_q;
      out_pprio_q <= pprio_q;
      out_head_q  <= out_head_d;
      out_cnt_q   <= occ_q;
    end
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    done_q  <= done_d;
    pid_q   <= pid_d;
    pprio_q <= pprio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpwq_pkg::StIdle;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    found_d    = found_q;
    done_d     = done_q;
    pid_d      = pid_q;
    pprio_d    = pprio_q;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_q[PosW-1:0];
    wr_data    = rd_data_q;
    out_load   = 1'b0;
    out_head_d = (occ_q == '0) ? CntW'(NUM_IDS) : CntW'(rd_data_q.id);

    unique case (state_q)
      dpwq_pkg::StIdle: begin
        if (accept) begin
          state_d = dpwq_pkg::StDispatch;
        end
      end
      dpwq_pkg::StDispatch: begin
        done_d  = 1'b0;
        pid_d   = '0;
        pprio_d = '0;
        idx_d   = '0;
        found_d = 1'b0;
        pos_d   = occ_q;
        state_d = dpwq_pkg::StHeadRd;
        unique case (req) inside
          dpwq_pkg::ReqInsert: begin
            if (32'(wid_q) < 32'(NUM_IDS) && 32'(occ_q) < 32'(NUM_IDS)) begin
              state_d = (occ_q == '0) ? dpwq_pkg::StInsWr : dpwq_pkg::StScanRd;
            end
          end
          dpwq_pkg::ReqRemove, dpwq_pkg::ReqPop: begin
            if (occ_q != '0) begin
              state_d = dpwq_pkg::StScanRd;
            end
          end
          dpwq_pkg::ReqDecrease: begin
            if (occ_q != '0) begin
              state_d = dpwq_pkg::StDecRd;
            end
          end
          dpwq_pkg::ReqClear: begin
            occ_d = '0;
          end
          default: ;
        endcase
      end
      dpwq_pkg::StScanRd: begin
        rd_addr = idx_q[PosW-1:0];
        state_d = dpwq_pkg::StScanChk;
      end
      dpwq_pkg::StScanChk: begin
        state_d = last ? dpwq_pkg::StHeadRd : dpwq_pkg::StScanRd;
        idx_d   = idx_p1;
        if (is_insert) begin
          if (rd_data_q.id == wid_q) begin
            state_d = dpwq_pkg::StHeadRd;
          end else begin
            if (!found_q && prio_q >= rd_data_q.prio) begin
              pos_d   = idx_q;
              found_d = 1'b1;
            end
            if (last) begin
              idx_d   = occ_q;
              state_d = dpwq_pkg::StShRd;
            end
          end
        end else if ((req == dpwq_pkg::ReqRemove && rd_data_q.id == wid_q) ||
                     (req == dpwq_pkg::ReqPop && rd_data_q.delay == '0)) begin
          done_d  = 1'b1;
          idx_d   = idx_q;
          state_d = dpwq_pkg::StShRd;
          if (req == dpwq_pkg::ReqPop) begin
            pid_d   = rd_data_q.id;
            pprio_d = rd_data_q.prio;
          end
        end
      end
      dpwq_pkg::StShRd: begin
        if (is_insert) begin
          rd_addr = idx_m1[PosW-1:0];
          state_d = (idx_q == pos_q) ? dpwq_pkg::StInsWr : dpwq_pkg::StShWr;
        end else begin
          rd_addr = idx_p1[PosW-1:0];
          if (last) begin
            occ_d   = occ_q - CntW'(1);
            state_d = dpwq_pkg::StHeadRd;
          end else begin
            state_d = dpwq_pkg::StShWr;
          end
        end
      end
      dpwq_pkg::StShWr: begin
        wr_en   = 1'b1;
        idx_d   = is_insert ? idx_m1 : idx_p1;
        state_d = dpwq_pkg::StShRd;
      end
      dpwq_pkg::StInsWr: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[PosW-1:0];
        wr_data = '{id: wid_q, prio: prio_q, delay: delay_q};
        occ_d   = occ_q + CntW'(1);
        done_d  = 1'b1;
        state_d = dpwq_pkg::StHeadRd;
      end
      dpwq_pkg::StDecRd: begin
        rd_addr = idx_q[PosW-1:0];
        state_d = dpwq_pkg::StDecWr;
      end
      dpwq_pkg::StDecWr: begin
        wr_en         = 1'b1;
        wr_data.delay = (rd_data_q.delay < dec_q) ? '0 : rd_data_q.delay - dec_q;
        idx_d         = idx_p1;
        state_d       = last ? dpwq_pkg::StHeadRd : dpwq_pkg::StDecRd;
      end
      dpwq_pkg::StHeadRd: begin
        state_d = dpwq_pkg::StHeadCap;
      end
      dpwq_pkg::StHeadCap: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = dpwq_pkg::StIdle;
        end
      end
      default: state_d = dpwq_pkg::StIdle;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !res_o.ready);

  assign req_i.ready           = (state_q == dpwq_pkg::StIdle);
  assign res_o.valid           = out_valid_q;
  assign res_o.done_res        = out_done_q;
  assign res_o.popped_id       = out_pid_q;
  assign res_o.popped_priority = out_pprio_q;
  assign res_o.head_id         = out_head_q;
  assign res_o.entry_count     = out_cnt_q;

endmodule

// File: design/dpwq_checker.sv
// Port-level checker for the delayed priority warning queue, bound to the top level.
// Depends on delayed_priority_warning_queue_macros.svh.
`include "delayed_priority_warning_queue_macros.svh"

module dpwq_checker #(
  parameter int NumIds = dpwq_pkg::NumIdsDefault,
  parameter int CntW   = 6
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       done_res_i,
  input logic [dpwq_pkg::IdW-1:0]   popped_id_i,
  input logic [dpwq_pkg::PrioW-1:0] popped_priority_i,
  input logic [CntW-1:0]            head_id_i,
  input logic [CntW-1:0]            entry_count_i
);

  `DPWQ_ASSERT_NOW(a_count_range, res_valid_i, 32'(entry_count_i) <= 32'(NumIds), "count too big")
  `DPWQ_ASSERT_NOW(a_head_empty, res_valid_i, (32'(head_id_i) == 32'(NumIds)) == (entry_count_i == '0), "head/count mismatch")
  `DPWQ_ASSERT_NOW(a_pop_zero, res_valid_i && !done_res_i, popped_id_i == '0 && popped_priority_i == '0, "popped fields not zero")
  `DPWQ_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(entry_count_i) && $stable(head_id_i), "result dropped")

endmodule

bind delayed_priority_warning_queue dpwq_checker #(
  .NumIds(NUM_IDS),
  .CntW  (CntW)
) u_dpwq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .done_res_i       (res_o.done_res),
  .popped_id_i      (res_o.popped_id),
  .popped_priority_i(res_o.popped_priority),
  .head_id_i        (res_o.head_id),
  .entry_count_i    (res_o.entry_count)
);
